>>> design/pf_pkg.sv
`timescale 1ns / 1ps

package pf_pkg;

  // letter codes and square geometry
  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_X = 5'd23;
  localparam logic [4:0] LETTER_Z = 5'd25;
  localparam logic [4:0] CELLS    = 5'd25;
  localparam logic [4:0] LETTERS  = 5'd26;
  localparam logic [2:0] SIDE     = 3'd5;

  // request function codes
  localparam logic [1:0] FN_KEY     = 2'd0;
  localparam logic [1:0] FN_KEY_END = 2'd1;
  localparam logic [1:0] FN_TEXT    = 2'd2;
  localparam logic [1:0] FN_END     = 2'd3;

  // control states
  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_FILL = 4'b0010,
    ST_CELL = 4'b0100,
    ST_LOAD = 4'b1000
  } state_t;

  // j shares the cell of i
  function automatic logic [4:0] fold_j(input logic [4:0] l);
    return (l == LETTER_J) ? LETTER_I : l;
  endfunction

  // row of a cell index 0..24
  function automatic logic [2:0] cell_row(input logic [4:0] p);
    logic [2:0] r;
    if (p >= 5'd20) r = 3'd4;
    else if (p >= 5'd15) r = 3'd3;
    else if (p >= 5'd10) r = 3'd2;
    else if (p >= 5'd5) r = 3'd1;
    else r = 3'd0;
    return r;
  endfunction

  // column of a cell index given its row
  function automatic logic [2:0] cell_col(input logic [4:0] p, input logic [2:0] r);
    logic [4:0] t;
    t = p - ({2'b00, r} << 2) - {2'b00, r};
    return t[2:0];
  endfunction

  // step one place along a row or column, wrapping at the edge
  function automatic logic [2:0] wrap_inc(input logic [2:0] v);
    return (v == SIDE - 3'd1) ? 3'd0 : v + 3'd1;
  endfunction

  // cell index from row and column
  function automatic logic [4:0] cell_idx(input logic [2:0] r, input logic [2:0] c);
    return ({2'b00, r} << 2) + {2'b00, r} + {2'b00, c};
  endfunction

endpackage

>>> design/playfair_encryptor.sv
`timescale 1ns / 1ps

// Playfair encryptor over letter codes 0 (a) .. 25 (z), 5x5 square.
// Input channel (in_valid/in_ready, func, letter): key letters, then a
// key end request, then plaintext letters and a message end request.
// Output channel (out_valid/out_ready, cipher_letter, last): each pair
// gives two letters, last high on the second.
// A key letter is handled in the idle state. A key end walks the 26 letters
// through the square memory write port, one per cycle, and the next request
// is taken once the walk ends. A request that completes a pair goes through
// the position memory read, then the square memory read, then into the
// output buffer; the next request is taken once the pair is in the buffer.
// Other requests are handled in the idle state as well.
// The two result letters sit in an output buffer, so requests keep flowing
// while the receiver stalls; only a second finished pair waits for the
// buffer to drain, holding in_ready low.
// Reset clears the used-letter mask, the fill count, the pending letter and
// the buffer; the square must be built again by a new key.
module playfair_encryptor (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] func,
  input  logic [4:0] letter,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [4:0] cipher_letter,
  output logic       last
);

  pf_pkg::state_t state;

  logic [25:0] used_mask;
  logic [4:0]  fill_count;
  logic [4:0]  fill_idx;
  logic        key_done;
  logic        pending_valid;
  logic [4:0]  pending_letter;
  logic [1:0]  out_cnt;

  logic [4:0] square_mem [25];
  logic [4:0] cell_mem [26];

  logic [4:0] cell_a, cell_b;
  logic [4:0] sq_a, sq_b;
  logic [4:0] res_a, res_b;

  logic       in_acc;
  logic       letter_ok;
  logic [4:0] place_src, place_ltr;
  logic       place_req, place_en;
  logic       pair_launch;
  logic [4:0] pair_b;
  logic [2:0] r1, c1, r2, c2;
  logic [4:0] enc_a, enc_b;

  // input handshake
  assign in_ready  = (state == pf_pkg::ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign letter_ok = (letter < pf_pkg::LETTERS);

  // square placement, from a key letter or the alphabet walk
  assign place_src = (state == pf_pkg::ST_FILL) ? fill_idx : letter;
  assign place_ltr = pf_pkg::fold_j(place_src);
  assign place_req = (state == pf_pkg::ST_FILL) ||
                     (in_acc && func == pf_pkg::FN_KEY && !key_done && letter_ok);
  assign place_en  = place_req && !used_mask[place_ltr] && (fill_count < pf_pkg::CELLS);

  // pair formation
  assign pair_launch = in_acc && key_done && pending_valid &&
                       ((func == pf_pkg::FN_TEXT && letter_ok) || func == pf_pkg::FN_END);
  assign pair_b = (func == pf_pkg::FN_END) ? pf_pkg::LETTER_Z :
                  (letter == pending_letter) ? pf_pkg::LETTER_X : letter;

  // cell positions to output cells
  assign r1 = pf_pkg::cell_row(cell_a);
  assign c1 = pf_pkg::cell_col(cell_a, r1);
  assign r2 = pf_pkg::cell_row(cell_b);
  assign c2 = pf_pkg::cell_col(cell_b, r2);

  always_comb begin
    if (r1 == r2) begin
      enc_a = pf_pkg::cell_idx(r1, pf_pkg::wrap_inc(c1));
      enc_b = pf_pkg::cell_idx(r2, pf_pkg::wrap_inc(c2));
    end else if (c1 == c2) begin
      enc_a = pf_pkg::cell_idx(pf_pkg::wrap_inc(r1), c1);
      enc_b = pf_pkg::cell_idx(pf_pkg::wrap_inc(r2), c2);
    end else begin
      enc_a = pf_pkg::cell_idx(r1, c2);
      enc_b = pf_pkg::cell_idx(r2, c1);
    end
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= pf_pkg::ST_IDLE;
      used_mask      <= '0;
      fill_count     <= '0;
      fill_idx       <= '0;
      key_done       <= 1'b0;
      pending_valid  <= 1'b0;
      pending_letter <= '0;
      out_cnt        <= '0;
    end else begin
      if (place_en) begin
        used_mask[place_ltr] <= 1'b1;
        if (place_ltr == pf_pkg::LETTER_I) begin
          used_mask[pf_pkg::LETTER_J] <= 1'b1;
        end
        fill_count <= fill_count + 5'd1;
      end
      if (out_valid && out_ready) begin
        out_cnt <= out_cnt - 2'd1;
      end
      unique case (state)
        pf_pkg::ST_IDLE: begin
          if (in_acc) begin
            unique case (func)
              pf_pkg::FN_KEY: begin
              end
              pf_pkg::FN_KEY_END: begin
                if (!key_done) begin
                  state    <= pf_pkg::ST_FILL;
                  fill_idx <= '0;
                end
              end
              pf_pkg::FN_TEXT: begin
                if (key_done && letter_ok) begin
                  if (!pending_valid) begin
                    pending_valid  <= 1'b1;
                    pending_letter <= letter;
                  end else begin
                    if (letter != pending_letter) begin
                      pending_valid <= 1'b0;
                    end
                    state <= pf_pkg::ST_CELL;
                  end
                end
              end
              pf_pkg::FN_END: begin
                if (key_done && pending_valid) begin
                  pending_valid <= 1'b0;
                  state         <= pf_pkg::ST_CELL;
                end
              end
              default: begin
              end
            endcase
          end
        end
        pf_pkg::ST_FILL: begin
          if (fill_idx == pf_pkg::LETTERS - 5'd1) begin
            state    <= pf_pkg::ST_IDLE;
            key_done <= 1'b1;
          end else begin
            fill_idx <= fill_idx + 5'd1;
          end
        end
        pf_pkg::ST_CELL: begin
          state <= pf_pkg::ST_LOAD;
        end
        pf_pkg::ST_LOAD: begin
          if (out_cnt == 2'd0) begin
            out_cnt <= 2'd2;
            state   <= pf_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= pf_pkg::ST_IDLE;
        end
      endcase
    end
  end

  // square and position memories
  always_ff @(posedge clk) begin
    if (place_en) begin
      square_mem[fill_count] <= place_ltr;
      cell_mem[place_ltr]    <= fill_count;
    end
    if (pair_launch) begin
      cell_a <= cell_mem[pf_pkg::fold_j(pending_letter)];
      cell_b <= cell_mem[pf_pkg::fold_j(pair_b)];
    end
    if (state == pf_pkg::ST_CELL) begin
      sq_a <= square_mem[enc_a];
      sq_b <= square_mem[enc_b];
    end
  end

  // output buffer
  always_ff @(posedge clk) begin
    if (state == pf_pkg::ST_LOAD && out_cnt == 2'd0) begin
      res_a <= sq_a;
      res_b <= sq_b;
    end
  end

  assign out_valid     = (out_cnt != 2'd0);
  assign cipher_letter = (out_cnt == 2'd2) ? res_a : res_b;
  assign last          = (out_cnt == 2'd1);

`ifndef SYNTH
  // the square stays frozen once complete
  a_key_sticky: assert property (@(posedge clk) disable iff (rst)
    key_done |=> key_done)
    else $error("key_done dropped");

  // a complete square has every cell filled
  a_square_full: assert property (@(posedge clk) disable iff (rst)
    key_done |-> fill_count == pf_pkg::CELLS)
    else $error("square incomplete after key end");

  // a finished pair lands in an empty buffer as two letters
  a_buffer_load: assert property (@(posedge clk) disable iff (rst)
    (state == pf_pkg::ST_LOAD && out_cnt == 2'd0) |=> out_cnt == 2'd2)
    else $error("pair not loaded into output buffer");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  typedef struct packed {
    logic [4:0] ch;
    logic       last;
  } cipher_out_t;

  typedef struct packed {
    logic [1:0] fn;
    logic [4:0] ltr;
    logic       quiet;
  } tour_row_t;

  localparam int DIRECTED_ROWS   = 25;
  localparam int RANDOM_REQUESTS = 1275;
  localparam int IDLE_LIMIT      = 2000;
  localparam int SETTLE_CYCLES   = 30;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic [1:0] func = pf_pkg::FN_KEY;
  logic [4:0] letter = 5'd0;
  logic       out_ready = 1'b0;
  logic       req_quiet = 1'b0;
  wire        in_ready;
  wire        out_valid;
  wire  [4:0] cipher_letter;
  wire        last;

  // directed requests; quiet rows are known to give no result
  tour_row_t tour [DIRECTED_ROWS] = '{
    '{pf_pkg::FN_TEXT,    5'd0,  1'b1},   // plaintext before the square exists
    '{pf_pkg::FN_END,     5'd0,  1'b1},   // message end before the square exists
    '{pf_pkg::FN_KEY,     5'd31, 1'b1},   // letter code out of range
    '{pf_pkg::FN_KEY,     5'd9,  1'b1},   // j lands in the cell of i
    '{pf_pkg::FN_KEY,     5'd8,  1'b1},   // i already placed through j
    '{pf_pkg::FN_KEY,     5'd25, 1'b1},
    '{pf_pkg::FN_KEY,     5'd0,  1'b1},
    '{pf_pkg::FN_KEY,     5'd25, 1'b1},   // repeated key letter
    '{pf_pkg::FN_KEY,     5'd16, 1'b1},
    '{pf_pkg::FN_KEY_END, 5'd0,  1'b1},
    '{pf_pkg::FN_KEY_END, 5'd31, 1'b1},   // second key end is ignored
    '{pf_pkg::FN_KEY,     5'd1,  1'b1},   // square is frozen
    '{pf_pkg::FN_END,     5'd0,  1'b1},   // nothing pending
    '{pf_pkg::FN_TEXT,    5'd0,  1'b0},
    '{pf_pkg::FN_TEXT,    5'd25, 1'b0},
    '{pf_pkg::FN_TEXT,    5'd23, 1'b0},
    '{pf_pkg::FN_TEXT,    5'd23, 1'b0},   // double x pads with x
    '{pf_pkg::FN_TEXT,    5'd31, 1'b1},   // bad plaintext code, x stays pending
    '{pf_pkg::FN_TEXT,    5'd9,  1'b0},
    '{pf_pkg::FN_TEXT,    5'd8,  1'b0},
    '{pf_pkg::FN_TEXT,    5'd9,  1'b0},   // i and j share one cell
    '{pf_pkg::FN_TEXT,    5'd25, 1'b0},
    '{pf_pkg::FN_END,     5'd0,  1'b0},   // lone z pads with z
    '{pf_pkg::FN_TEXT,    5'd4,  1'b0},
    '{pf_pkg::FN_END,     5'd31, 1'b0}
  };

  // predicted square and pairing state
  logic [4:0]  sq_letter [25];
  logic [4:0]  sq_cell [26];
  logic [25:0] placed = '0;
  int          filled = 0;
  bit          square_ready = 1'b0;
  bit          held_v = 1'b0;
  logic [4:0]  held_letter = 5'd0;

  cipher_out_t cipher_due [$];
  int          errors = 0;
  int          idle_cycles = 0;

  logic [7:0]  ready_rot = 8'b1011_0010;
  int          stall_mode = 0;

  always #5 clk = ~clk;

  playfair_encryptor dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .func         (func),
    .letter       (letter),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .cipher_letter(cipher_letter),
    .last         (last)
  );

  task automatic note_error(input string what);
    errors++;
    if (errors <= 10) $display("ERROR at %0t: %s", $time, what);
  endtask

  // next free cell gets the letter, j folded into i
  task automatic place_key_letter(input logic [4:0] l);
    logic [4:0] f;
    f = (l == pf_pkg::LETTER_J) ? pf_pkg::LETTER_I : l;
    if (!placed[f] && filled < 25) begin
      sq_letter[filled] = f;
      sq_cell[f] = 5'(filled);
      if (f == pf_pkg::LETTER_I) begin
        sq_cell[pf_pkg::LETTER_J] = 5'(filled);
        placed[pf_pkg::LETTER_J] = 1'b1;
      end
      placed[f] = 1'b1;
      filled++;
    end
  endtask

  // usual playfair rules on one pair
  task automatic encipher_pair(input logic [4:0] a, input logic [4:0] b, input bit record);
    int p, q, r1, c1, r2, c2, o1, o2;
    p = sq_cell[a];
    q = sq_cell[b];
    r1 = p / 5;
    c1 = p % 5;
    r2 = q / 5;
    c2 = q % 5;
    if (r1 == r2) begin
      o1 = r1 * 5 + (c1 + 1) % 5;
      o2 = r2 * 5 + (c2 + 1) % 5;
    end else if (c1 == c2) begin
      o1 = ((r1 + 1) % 5) * 5 + c1;
      o2 = ((r2 + 1) % 5) * 5 + c2;
    end else begin
      o1 = r1 * 5 + c2;
      o2 = r2 * 5 + c1;
    end
    if (record) begin
      cipher_due.insert(cipher_due.size(), cipher_out_t'{ch: sq_letter[o1], last: 1'b0});
      cipher_due.insert(cipher_due.size(), cipher_out_t'{ch: sq_letter[o2], last: 1'b1});
    end
  endtask

  // advance the predicted state by one accepted request
  task automatic apply_request(input logic [1:0] fn, input logic [4:0] l, input bit record);
    case (fn)
      pf_pkg::FN_KEY: begin
        if (!square_ready && l < pf_pkg::LETTERS) place_key_letter(l);
      end
      pf_pkg::FN_KEY_END: begin
        if (!square_ready) begin
          for (int k = 0; k < 26; k++) place_key_letter(5'(k));
          square_ready = 1'b1;
        end
      end
      pf_pkg::FN_TEXT: begin
        if (square_ready && l < pf_pkg::LETTERS) begin
          if (!held_v) begin
            held_v = 1'b1;
            held_letter = l;
          end else if (l == held_letter) begin
            encipher_pair(held_letter, pf_pkg::LETTER_X, record);
          end else begin
            held_v = 1'b0;
            encipher_pair(held_letter, l, record);
          end
        end
      end
      default: begin
        if (square_ready && held_v) begin
          held_v = 1'b0;
          encipher_pair(held_letter, pf_pkg::LETTER_Z, record);
        end
      end
    endcase
  endtask

  // request and result monitor, plus idle watchdog
  always @(posedge clk) begin : watch
    cipher_out_t due;
    if (!rst) begin
      if (in_valid && in_ready) apply_request(func, letter, !req_quiet);
      if (out_valid && out_ready) begin
        if (cipher_due.size() == 0) begin
          note_error($sformatf("unexpected cipher %0d last %0d", cipher_letter, last));
        end else begin
          due = cipher_due.pop_front();
          if (cipher_letter !== due.ch || last !== due.last)
            note_error($sformatf("cipher %0d last %0d, expected cipher %0d last %0d",
                                 cipher_letter, last, due.ch, due.last));
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // receiver stalls, switching between a few styles
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if ($urandom_range(0, 149) == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        2: out_ready <= ($urandom_range(0, 3) == 0);
        default: begin
          ready_rot = {ready_rot[6:0], ready_rot[7]};
          out_ready <= ready_rot[0];
        end
      endcase
    end
  end

  task automatic send_request(input logic [1:0] f, input logic [4:0] l, input logic q);
    in_valid <= 1'b1;
    func <= f;
    letter <= l;
    req_quiet <= q;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // sender bursts with gaps between them
  task automatic pace(inout int burst);
    if (burst == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
    end
    burst--;
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (cipher_due.size() != 0);
  endtask

  initial begin
    int burst;
    int useful;
    int pick;
    logic [1:0] f;
    logic [4:0] l;
    logic [4:0] prev_text;
    burst = 0;
    useful = 0;
    prev_text = 5'd0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed part
    for (int i = 0; i < DIRECTED_ROWS; i++) begin
      pace(burst);
      send_request(tour[i].fn, tour[i].ltr, tour[i].quiet);
    end
    drain_results();
    burst = 0;

    // random plaintext with repeats, i/j mixes, ends and noise
    while (useful < RANDOM_REQUESTS) begin
      pick = $urandom_range(0, 99);
      l = 5'($urandom_range(0, 31));
      if (pick < 72) begin
        f = pf_pkg::FN_TEXT;
        if ($urandom_range(0, 4) == 0) l = prev_text;
        else if ($urandom_range(0, 9) == 0)
          l = $urandom_range(0, 1) ? pf_pkg::LETTER_I : pf_pkg::LETTER_J;
        else l = 5'($urandom_range(0, 25));
        prev_text = l;
      end else if (pick < 84) begin
        f = pf_pkg::FN_END;
      end else if (pick < 90) begin
        f = pf_pkg::FN_TEXT;
        l = 5'($urandom_range(26, 31));
      end else if (pick < 95) begin
        f = pf_pkg::FN_KEY;
      end else begin
        f = pf_pkg::FN_KEY_END;
      end
      pace(burst);
      send_request(f, l, 1'b0);
      useful++;
      if ($urandom_range(0, 199) == 0) begin
        drain_results();
        burst = 0;
      end
    end

    // wind down
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0 && cipher_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
